>>> rtl/weo_pkg.sv
// Package: shared types, constants, register indexes and sine table for the odometry block.
`timescale 1ns / 1ps
package weo_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int IDX_W      = $clog2(SINE_DEPTH);
  localparam int ANGLE_STEP = 65536 / SINE_DEPTH;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;
  typedef logic signed [15:0]       trig_t;
  typedef trig_t sine_tab_t [SINE_DEPTH];

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_COUNT_MODULUS = 2'd0,
    REG_HALF_COUNT    = 2'd1,
    REG_SPEED_GAIN    = 2'd2,
    REG_PERIOD_GAIN   = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_L,
    ST_MUL_R,
    ST_SAT_R,
    ST_MUL_S,
    ST_STEP,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC_Y,
    ST_FIN
  } state_t;

  // Quarter-wave sine in Q1.15, Taylor series to the ninth power
  function automatic longint unsigned quarter_sine(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    x    = (r * PI_Q30) >> 15;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 72;
    acc  = acc + term;
    acc  = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) acc = 64'd32767;
    return acc;
  endfunction

  // Full-wave table from quadrant mirroring and negation
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned b;
    longint unsigned r;
    longint unsigned v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      b = longint'(i) * ANGLE_STEP;
      r = b & 64'h3FFF;
      if (b[14]) r = 64'd16384 - r;
      v = quarter_sine(r);
      tab[i] = b[15] ? -$signed(v[15:0]) : $signed(v[15:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> rtl/odo_in_if.sv
// Interface: input channel carrying encoder readings and heading.
`timescale 1ns / 1ps
interface odo_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_reading;
  logic [11:0] right_reading;
  logic [15:0] heading;

  modport source (output valid, left_reading, right_reading, heading, input ready);
  modport sink   (input valid, left_reading, right_reading, heading, output ready);
endinterface

>>> rtl/odo_out_if.sv
// Interface: output channel carrying speeds and position.
`timescale 1ns / 1ps
interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;
  logic signed [47:0] pos_x_out;
  logic signed [47:0] pos_y_out;

  modport source (output valid, left_speed, right_speed, pos_x_out, pos_y_out, input ready);
  modport sink   (input valid, left_speed, right_speed, pos_x_out, pos_y_out, output ready);
endinterface

>>> rtl/weo_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module weo_mul import weo_pkg::*; (
  input  logic      clk,
  input  mul_op_t   a,
  input  mul_op_t   b,
  output mul_prod_t p
);

  // Register the product for the next sequencer step
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/weo_sine.sv
// Sine table lookup with registered read data.
`timescale 1ns / 1ps
module weo_sine import weo_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  output trig_t            val
);

  // Read one table entry per cycle
  always_ff @(posedge clk) begin
    val <= SINE_TAB[idx];
  end

endmodule

>>> rtl/wheel_encoder_odometry.sv
// Top level: differential-drive odometry with a shared multiplier sequencer.
//
// Usage:
//   The input channel takes one transaction per control tick: left and right
//   absolute encoder readings and the heading as a binary angle. The output
//   channel returns one transaction per input: the averaged Q16.16 wheel
//   speeds and the updated 48-bit x and y positions.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle, which the block
//   itself does not enforce; they take effect on the next input. An item is
//   accepted in the idle state and then passes through ten sequencer steps,
//   set by the single shared multiplier that performs five products in turn;
//   the next input is accepted only after the last step returns to idle.
//   The result sits in an output register, so the next input is accepted
//   while a result still waits. If the receiver stalls, the finished next
//   item waits in its last step until the output register frees up.
//   Reset (synchronous, active high) clears previous counts, speeds and
//   positions and loads the default register values.
`timescale 1ns / 1ps
module wheel_encoder_odometry import weo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  odo_in_if.sink      in_ch,
  odo_out_if.source   out_ch
);

  state_t state, state_next;

  logic [12:0] count_modulus;
  logic [11:0] half_count;
  logic [31:0] speed_gain;
  logic [31:0] period_gain;

  logic [11:0]        left_cur, right_cur;
  logic [15:0]        heading;
  logic [11:0]        prev_left_count, prev_right_count;
  logic signed [31:0] prev_left_speed, prev_right_speed;
  logic signed [15:0] dl, dr;
  logic signed [31:0] vl, vr;
  logic signed [32:0] step;
  trig_t              cos_val, sin_val;
  logic signed [47:0] pos_x, pos_y;

  mul_op_t          mul_a, mul_b;
  mul_prod_t        prod;
  logic [IDX_W-1:0] sine_idx;
  trig_t            sine_val;
  logic             out_free;
  logic signed [32:0] sum_l, sum_r, sum_v;

  weo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  weo_sine u_sine (.clk(clk), .idx(sine_idx), .val(sine_val));

  // Unwrap a reading change by the full-turn count
  function automatic logic signed [15:0] unwrap(input logic [11:0] now,
                                               input logic [11:0] prev,
                                               input logic [11:0] half,
                                               input logic [12:0] modulus);
    logic signed [15:0] d;
    logic signed [15:0] h;
    logic signed [15:0] m;
    d = $signed({4'b0, now}) - $signed({4'b0, prev});
    h = $signed({4'b0, half});
    m = $signed({3'b0, modulus});
    if (d > h) d = d - m;
    else if (d < -h) d = d + m;
    return d;
  endfunction

  // Saturate a product to signed 32 bits
  function automatic logic signed [31:0] sat32(input mul_prod_t v);
    if (v > mul_prod_t'(64'sd2147483647)) return 32'sh7FFF_FFFF;
    if (v < -mul_prod_t'(64'sd2147483648)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign sum_l = 33'(vl) + 33'(prev_left_speed);
  assign sum_r = 33'(vr) + 33'(prev_right_speed);
  assign sum_v = 33'(vl) + 33'(vr);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_ch.valid) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_SAT_R;
      ST_SAT_R: state_next = ST_MUL_S;
      ST_MUL_S: state_next = ST_STEP;
      ST_STEP:  state_next = ST_MUL_X;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_ACC_Y;
      ST_ACC_Y: state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands and table index per step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    sine_idx = heading[15 -: IDX_W];
    unique case (state)
      ST_DIFF:  sine_idx = heading[15 -: IDX_W] + IDX_W'(SINE_DEPTH / 4);
      ST_MUL_L: begin
        mul_a = -MUL_W'(dl);
        mul_b = $signed({2'b0, speed_gain});
      end
      ST_MUL_R: begin
        mul_a = MUL_W'(dr);
        mul_b = $signed({2'b0, speed_gain});
      end
      ST_MUL_S: begin
        mul_a = MUL_W'(sum_v);
        mul_b = $signed({2'b0, period_gain});
      end
      ST_MUL_X: begin
        mul_a = MUL_W'(step);
        mul_b = MUL_W'(cos_val);
      end
      ST_MUL_Y: begin
        mul_a = MUL_W'(step);
        mul_b = MUL_W'(sin_val);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_modulus <= 13'd4090;
      half_count    <= 12'd2044;
      speed_gain    <= 32'd65536;
      period_gain   <= 32'd4294967;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COUNT_MODULUS: count_modulus <= cfg_data[12:0];
        REG_HALF_COUNT:    half_count    <= cfg_data[11:0];
        REG_SPEED_GAIN:    speed_gain    <= cfg_data;
        REG_PERIOD_GAIN:   period_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_count  <= '0;
      prev_right_count <= '0;
      prev_left_speed  <= '0;
      prev_right_speed <= '0;
      pos_x            <= '0;
      pos_y            <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          left_cur  <= in_ch.left_reading;
          right_cur <= in_ch.right_reading;
          heading   <= in_ch.heading;
        end
        ST_DIFF: begin
          dl <= unwrap(left_cur, prev_left_count, half_count, count_modulus);
          dr <= unwrap(right_cur, prev_right_count, half_count, count_modulus);
        end
        ST_MUL_L: cos_val <= sine_val;
        ST_MUL_R: begin
          sin_val <= sine_val;
          vl      <= sat32(prod);
        end
        ST_SAT_R: vr <= sat32(prod);
        ST_STEP:  step <= prod[65:33];
        ST_MUL_Y: pos_x <= pos_x + prod[62:15];
        ST_ACC_Y: pos_y <= pos_y + prod[62:15];
        ST_FIN: if (out_free) begin
          prev_left_count  <= left_cur;
          prev_right_count <= right_cur;
          prev_left_speed  <= vl;
          prev_right_speed <= vr;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_ch.left_speed  <= sum_l[32:1];
      out_ch.right_speed <= sum_r[32:1];
      out_ch.pos_x_out   <= pos_x;
      out_ch.pos_y_out   <= pos_y;
    end
  end

endmodule

>>> rtl/weo_checker.sv
// Checker: port-level assertions for the odometry block, bound to the top level.
`timescale 1ns / 1ps
module weo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] left_speed,
  input logic [47:0] pos_x_out
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(left_speed) && $stable(pos_x_out))
    else $error("stalled result changed");

  // Busy after each accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // No result right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind wheel_encoder_odometry weo_checker u_weo_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .left_speed(out_ch.left_speed),
  .pos_x_out(out_ch.pos_x_out)
);

>>> tb/sv/tb.sv
// Testbench: wheel odometry block against an in-bench predictor of speeds and positions.
`timescale 1ns / 1ps
module tb;
  import weo_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int N_RANDOM       = 1030;

  typedef struct packed {
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
  } odo_result_t;

  typedef struct {
    logic [11:0] lr;
    logic [11:0] rr;
    logic [15:0] hd;
    bit          has_exp;
    odo_result_t exp_res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();

  wheel_encoder_odometry dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor copy of configuration and state
  longint unsigned cur_modulus, cur_half, cur_speed_gain, cur_period_gain;
  logic [11:0]  last_left_count, last_right_count;
  longint       last_left_speed, last_right_speed;
  logic [47:0]  odo_x, odo_y;

  odo_result_t expected_odo[$];
  int          error_count;
  int          idle_cycles;
  bit          sink_stall_on;
  bit          src_gap_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH %s got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint floor_div_pow2(input longint v, input int sh);
    return v >>> sh;
  endfunction

  function automatic longint sat_32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Taylor quarter-wave sine, Q1.15
  function automatic longint quarter_wave(input longint unsigned r);
    longint unsigned x, x2, t, a;
    int divs[4];
    divs = '{6, 20, 42, 72};
    x = (r * 64'd3373259426) >> 15;
    x2 = (x * x) >> 30;
    t = x;
    a = x;
    for (int k = 0; k < 4; k++) begin
      t = ((t * x2) >> 30) / divs[k];
      if (k % 2 == 0) a = a - t;
      else a = a + t;
    end
    a = (a + 64'd16384) >> 15;
    if (a > 64'd32767) a = 64'd32767;
    return longint'(a);
  endfunction

  function automatic longint heading_sine(input logic [15:0] ang);
    longint unsigned idx, b, r, q;
    longint v;
    idx = (longint'(ang) * SINE_DEPTH) >> 16;
    b = (idx * 65536) / SINE_DEPTH;
    q = (b >> 14) & 3;
    r = b & 64'h3FFF;
    if (q[0]) r = 16384 - r;
    v = quarter_wave(r);
    return q[1] ? -v : v;
  endfunction

  function automatic longint unwrap_delta(input logic [11:0] now, input logic [11:0] prev);
    longint d;
    d = longint'(now) - longint'(prev);
    if (d > longint'(cur_half)) d -= longint'(cur_modulus);
    else if (d < -longint'(cur_half)) d += longint'(cur_modulus);
    return d;
  endfunction

  // Advance the odometry state by one tick and return the result
  function automatic odo_result_t odometry_step(input logic [11:0] lr, input logic [11:0] rr,
                                                input logic [15:0] hd);
    odo_result_t res;
    longint dl, dr, vl, vr, sum, stp, c, s;
    logic [127:0] mag;
    logic [127:0] prod;
    dl = unwrap_delta(lr, last_left_count);
    dr = unwrap_delta(rr, last_right_count);
    vl = sat_32(-dl * longint'(cur_speed_gain));
    vr = sat_32(dr * longint'(cur_speed_gain));
    res.left_speed = 32'(floor_div_pow2(vl + last_left_speed, 1));
    res.right_speed = 32'(floor_div_pow2(vr + last_right_speed, 1));
    sum = vl + vr;
    mag = (sum < 0) ? 128'(-sum) : 128'(sum);
    prod = mag * 128'(cur_period_gain);
    stp = longint'(prod >> 33);
    if (sum < 0) begin
      if (prod[32:0] != 0) stp = stp + 1;
      stp = -stp;
    end
    c = heading_sine(hd + 16'd16384);
    s = heading_sine(hd);
    last_left_count = lr;
    last_right_count = rr;
    last_left_speed = vl;
    last_right_speed = vr;
    odo_x = odo_x + 48'(floor_div_pow2(stp * c, 15));
    odo_y = odo_y + 48'(floor_div_pow2(stp * s, 15));
    res.pos_x = odo_x;
    res.pos_y = odo_y;
    return res;
  endfunction

  function automatic bit idle_draw();
    return $urandom_range(99) < 20;
  endfunction

  // Write one register at a falling edge, mirror it in the predictor
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COUNT_MODULUS: cur_modulus = val & 32'h1FFF;
      REG_HALF_COUNT:    cur_half = val & 32'hFFF;
      REG_SPEED_GAIN:    cur_speed_gain = val;
      REG_PERIOD_GAIN:   cur_period_gain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one transaction, with optional gap before it
  task automatic send_tick(input logic [11:0] lr, input logic [11:0] rr, input logic [15:0] hd);
    while (src_gap_on && idle_draw()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_reading <= lr;
    in_ch.right_reading <= rr;
    in_ch.heading <= hd;
    expected_odo.push_back(odometry_step(lr, rr, hd));
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    // Leave this falling edge to the drop of valid
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (expected_odo.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    odo_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_odo.size() == 0) begin
        report_mismatch("unexpected result", 48'(out_ch.pos_x_out), 48'h0);
      end else begin
        want = expected_odo.pop_front();
        if (out_ch.left_speed !== want.left_speed)
          report_mismatch("left_speed", 48'(out_ch.left_speed), 48'(want.left_speed));
        if (out_ch.right_speed !== want.right_speed)
          report_mismatch("right_speed", 48'(out_ch.right_speed), 48'(want.right_speed));
        if (out_ch.pos_x_out !== want.pos_x)
          report_mismatch("pos_x_out", out_ch.pos_x_out, want.pos_x);
        if (out_ch.pos_y_out !== want.pos_y)
          report_mismatch("pos_y_out", out_ch.pos_y_out, want.pos_y);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("wheel_encoder_odometry test failed");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= !(sink_stall_on && idle_draw());
  end

  // Directed rows and random ticks
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [11:0] l, r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_COUNT_MODULUS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_reading = '0;
    in_ch.right_reading = '0;
    in_ch.heading = '0;
    out_ch.ready = 1'b1;
    sink_stall_on = 1'b0;
    src_gap_on = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    cur_modulus = 4090;
    cur_half = 2044;
    cur_speed_gain = 65536;
    cur_period_gain = 4294967;
    last_left_count = '0;
    last_right_count = '0;
    last_left_speed = 0;
    last_right_speed = 0;
    odo_x = '0;
    odo_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero motion after reset, wraps, extremes, all quadrants
    rows.push_back('{12'd0, 12'd0, 16'd0, 1'b1, '{32'sd0, 32'sd0, 48'sd0, 48'sd0}});
    rows.push_back('{12'd10, 12'd10, 16'd0, 1'b0, '0});
    rows.push_back('{12'd4095, 12'd4095, 16'd16384, 1'b0, '0});
    rows.push_back('{12'd0, 12'd0, 16'd32768, 1'b0, '0});
    rows.push_back('{12'd2044, 12'd2045, 16'd49152, 1'b0, '0});
    rows.push_back('{12'd0, 12'd0, 16'd65535, 1'b0, '0});
    rows.push_back('{12'd2045, 12'd2044, 16'd12345, 1'b0, '0});
    rows.push_back('{12'd4095, 12'd0, 16'd40000, 1'b0, '0});
    rows.push_back('{12'd0, 12'd4095, 16'd63, 1'b0, '0});
    rows.push_back('{12'd2730, 12'd1365, 16'd21845, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_tick(row.lr, row.rr, row.hd);
      if (row.has_exp && expected_odo[$] !== row.exp_res)
        report_mismatch("directed row predictor", 48'(i), 48'h0);
    end
    wait_idle();

    // Extreme gains: saturate speeds, full period, odd modulus values
    write_reg(REG_SPEED_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD_GAIN, 32'hFFFF_FFFF);
    send_tick(12'd100, 12'd4000, 16'd8192);
    send_tick(12'd4000, 12'd100, 16'd24576);
    send_tick(12'd100, 12'd100, 16'd57344);
    wait_idle();
    write_reg(REG_COUNT_MODULUS, 32'd0);
    write_reg(REG_HALF_COUNT, 32'd0);
    write_reg(REG_SPEED_GAIN, 32'd0);
    write_reg(REG_PERIOD_GAIN, 32'd0);
    send_tick(12'd5, 12'd4090, 16'd1000);
    wait_idle();
    write_reg(REG_SPEED_GAIN, 32'd1);
    write_reg(REG_COUNT_MODULUS, 32'h1FFF);
    write_reg(REG_HALF_COUNT, 32'hFFF);
    send_tick(12'd4095, 12'd0, 16'd2000);
    send_tick(12'd0, 12'd4095, 16'd3000);
    wait_idle();

    // Random phases over several register settings
    sink_stall_on = 1'b1;
    src_gap_on = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COUNT_MODULUS, 32'd4096);
          write_reg(REG_HALF_COUNT, 32'd2048);
          write_reg(REG_SPEED_GAIN, 32'd65536);
          write_reg(REG_PERIOD_GAIN, 32'd4294967);
        end
        1: begin
          write_reg(REG_COUNT_MODULUS, 32'd1);
          write_reg(REG_HALF_COUNT, 32'd1);
          write_reg(REG_SPEED_GAIN, $urandom);
          write_reg(REG_PERIOD_GAIN, $urandom);
        end
        2: begin
          write_reg(REG_COUNT_MODULUS, $urandom_range(8191));
          write_reg(REG_HALF_COUNT, $urandom_range(4095));
          write_reg(REG_SPEED_GAIN, 32'hFFFF_FFFF);
          write_reg(REG_PERIOD_GAIN, 32'hFFFF_FFFF);
        end
        3: begin
          sink_stall_on = 1'b0;
          src_gap_on = 1'b0;
          write_reg(REG_COUNT_MODULUS, 32'd4090);
          write_reg(REG_HALF_COUNT, 32'd2044);
          write_reg(REG_SPEED_GAIN, $urandom_range(2000000));
          write_reg(REG_PERIOD_GAIN, $urandom);
        end
        default: begin
          sink_stall_on = 1'b1;
          src_gap_on = 1'b1;
          write_reg(REG_SPEED_GAIN, $urandom);
          write_reg(REG_PERIOD_GAIN, $urandom_range(100000));
        end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        // Mostly small wheel motion, sometimes arbitrary jumps
        if ($urandom_range(3) == 0) begin
          l = 12'($urandom);
          r = 12'($urandom);
        end else begin
          l = last_left_count + 12'($urandom_range(80)) - 12'd40;
          r = last_right_count + 12'($urandom_range(80)) - 12'd40;
        end
        send_tick(l, r, 16'($urandom));
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("wheel_encoder_odometry test passed");
    end else begin
      $display("wheel_encoder_odometry test failed");
    end
    $finish;
  end

endmodule
